// ===== rtl/ste_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ste_pkg
// Shared constants and types for the sorted tick event table.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned VALUE_W     = 16;

  localparam logic              REQ_SET  = 1'b0;
  localparam logic              REQ_GET  = 1'b1;
  localparam logic [VALUE_W-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic               upd_en;
    logic               ins_en;
    logic [TICK_W-1:0]  tick;
    logic [VALUE_W-1:0] value;
  } ste_cmd_t;

  typedef struct packed {
    logic ins;
    logic le;
    logic eq;
  } ste_stat_t;

endpackage : ste_pkg
`default_nettype wire

// ===== rtl/sorted_tick_event_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_tick_event_table
// Table of events kept in ascending tick order in a row of cells; set
// inserts or overwrites, get returns the value at or before a tick.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i, in_stall_o | req_type_i, tick_i, new_value_i
//  out     | out_valid_o, out_stall_i | read_value_o, found_o, accepted_o
//
//  a word is registered on acceptance and acted on by all cells together once
//  the result stage is free, its result registered: one word a cycle throughput
//  unless the output stalls, set by the compare and shift across the cells.
//  reset empties the table (entry count to zero) and clears both valid flags.
//  a stalled result holds the request stage, which then stalls the input.
// ----------------------------------------------------------------------------
module sorted_tick_event_table
  import ste_pkg::*;
(
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  logic                      in_valid_i,
  output logic                            in_stall_o,
  input  wire  logic                      req_type_i,
  input  wire  logic [TICK_W-1:0]         tick_i,
  input  wire  logic signed [VALUE_W-1:0] new_value_i,
  output logic                            out_valid_o,
  input  wire  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0]       read_value_o,
  output logic                            found_o,
  output logic                            accepted_o
);

  logic               req_valid_q;
  logic               req_type_q;
  logic [TICK_W-1:0]  req_tick_q;
  logic [VALUE_W-1:0] req_value_q;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_found_q, out_found_d;
  logic               out_acc_q, out_acc_d;

  logic     out_free, go, full, any_eq, any_le;
  ste_cmd_t cmd;

  logic [TICK_W-1:0]  cell_tick  [TABLE_DEPTH];
  logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];
  ste_stat_t          cell_stat  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec, le_vec, ins_vec, occ_vec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign go         = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign full       = (count_q == COUNT_W'(TABLE_DEPTH));
  assign any_eq     = |eq_vec;
  assign any_le     = |le_vec;

  always_comb begin
    cmd.upd_en = go && (req_type_q == REQ_SET);
    cmd.ins_en = go && (req_type_q == REQ_SET) && !any_eq && !full;
    cmd.tick   = req_tick_q;
    cmd.value  = req_value_q;
  end

  // row of cells
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    assign occ_vec[k] = (COUNT_W'(k) < count_q);
    if (k == 0) begin : g_first
      ste_cell u_cell (
        .clk_i        (clk_i),
        .occ_i        (occ_vec[k]),
        .cmd_i        (cmd),
        .prev_ins_i   (1'b0),
        .prev_tick_i  ('0),
        .prev_value_i ('0),
        .tick_o       (cell_tick[k]),
        .value_o      (cell_value[k]),
        .stat_o       (cell_stat[k])
      );
    end else begin : g_next
      ste_cell u_cell (
        .clk_i        (clk_i),
        .occ_i        (occ_vec[k]),
        .cmd_i        (cmd),
        .prev_ins_i   (ins_vec[k-1]),
        .prev_tick_i  (cell_tick[k-1]),
        .prev_value_i (cell_value[k-1]),
        .tick_o       (cell_tick[k]),
        .value_o      (cell_value[k]),
        .stat_o       (cell_stat[k])
      );
    end
    assign eq_vec[k]  = cell_stat[k].eq;
    assign le_vec[k]  = cell_stat[k].le;
    assign ins_vec[k] = cell_stat[k].ins;
  end

  // floor select: last cell at or below the tick
  always_comb begin
    logic [VALUE_W-1:0] sel;
    sel = '0;
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
      if (le_vec[k] && ((k == TABLE_DEPTH - 1) || !le_vec[(k + 1) % TABLE_DEPTH])) begin
        sel = sel | cell_value[k];
      end
    end
    if (req_type_q == REQ_GET) begin
      out_value_d = any_le ? sel : NO_VALUE;
      out_found_d = any_le;
      out_acc_d   = 1'b1;
    end else begin
      out_value_d = NO_VALUE;
      out_found_d = 1'b0;
      out_acc_d   = any_eq || !full;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins_en) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (!in_stall_o) begin
        req_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q  <= req_type_i;
      req_tick_q  <= tick_i;
      req_value_q <= new_value_i;
    end
    if (go) begin
      out_value_q <= out_value_d;
      out_found_q <= out_found_d;
      out_acc_q   <= out_acc_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign found_o      = out_found_q;
  assign accepted_o   = out_acc_q;

endmodule : sorted_tick_event_table
`default_nettype wire

// ===== rtl/ste_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ste_cell
// One table slot: compares its tick with the request tick, takes the new
// entry or its left neighbour's entry on insert, overwrites its value on a
// matching set.
// ----------------------------------------------------------------------------
module ste_cell
  import ste_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  logic               occ_i,
  input  wire  ste_cmd_t           cmd_i,
  input  wire  logic               prev_ins_i,
  input  wire  logic [TICK_W-1:0]  prev_tick_i,
  input  wire  logic [VALUE_W-1:0] prev_value_i,
  output logic [TICK_W-1:0]        tick_o,
  output logic [VALUE_W-1:0]       value_o,
  output ste_stat_t                stat_o
);

  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [VALUE_W-1:0] value_q, value_d;

  always_comb begin
    stat_o.eq  = occ_i && (tick_q == cmd_i.tick);
    stat_o.le  = occ_i && (tick_q <= cmd_i.tick);
    stat_o.ins = !occ_i || (tick_q >= cmd_i.tick);
  end

  always_comb begin
    tick_d  = tick_q;
    value_d = value_q;
    if (cmd_i.ins_en && stat_o.ins) begin
      if (prev_ins_i) begin
        tick_d  = prev_tick_i;
        value_d = prev_value_i;
      end else begin
        tick_d  = cmd_i.tick;
        value_d = cmd_i.value;
      end
    end else if (cmd_i.upd_en && stat_o.eq) begin
      value_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q  <= tick_d;
    value_q <= value_d;
  end

  assign tick_o  = tick_q;
  assign value_o = value_q;

endmodule : ste_cell
`default_nettype wire
